// ===== sv/bpsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap pixel decoder package
// shared constants, codes, types and channel helpers
// ----------------------------------------------------------------------------
package bpsd_pkg;

    localparam int DEF_MAX_WIDTH   = 4096;
    localparam int DEF_MAX_HEIGHT  = 4096;
    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_AW          = 8;
    localparam int COLOR_W         = 24;
    localparam int DIM_W           = 13;
    localparam int MASK_W          = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] FMT_PAL8   = 2'd0;
    localparam logic [1:0] FMT_MASK16 = 2'd1;
    localparam logic [1:0] FMT_RGB24  = 2'd2;
    localparam logic [1:0] FMT_MASK32 = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_MASK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_MASK = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_MASK  = 3'd5;

    localparam logic ACT_PIXEL   = 1'b0;
    localparam logic ACT_PALETTE = 1'b1;

    localparam logic [MASK_W-1:0] DEF16_R = 32'h0000_7C00;
    localparam logic [MASK_W-1:0] DEF16_G = 32'h0000_03E0;
    localparam logic [MASK_W-1:0] DEF16_B = 32'h0000_001F;
    localparam logic [MASK_W-1:0] DEF32_R = 32'h00FF_0000;
    localparam logic [MASK_W-1:0] DEF32_G = 32'h0000_FF00;
    localparam logic [MASK_W-1:0] DEF32_B = 32'h0000_00FF;

    typedef struct packed {
        logic [1:0]        fmt;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [MASK_W-1:0] red_mask;
        logic [MASK_W-1:0] green_mask;
        logic [MASK_W-1:0] blue_mask;
    } t_cfg;

    typedef struct packed {
        logic        kind;
        logic [1:0]  fmt;
        logic        row_end;
        logic        image_end;
        logic [31:0] data;
    } t_cmd;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       row_end;
        logic       image_end;
    } t_pix;

    function automatic logic [4:0] trailing_zeros(input logic [MASK_W-1:0] mask);
        logic [4:0] tz;
        tz = 5'd31;
        for (int i = MASK_W - 1; i >= 0; i--) begin
            if (mask[i]) begin
                tz = 5'(i);
            end
        end
        return tz;
    endfunction

    function automatic logic [7:0] mask_channel(input logic [31:0] word,
                                                input logic [MASK_W-1:0] mask,
                                                input logic [4:0] sh);
        logic [31:0] v;
        v = (word & mask) >> sh;
        return v[7:0];
    endfunction

endpackage

// ===== sv/bpsd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generic ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module bpsd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/bpsd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// small queue
// register based first-in first-out buffer with fill count
// ----------------------------------------------------------------------------
module bpsd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count,
    output logic                       o_full,
    output logic                       o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);

endmodule

// ===== sv/bpsd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap decoder front end
// takes items, gathers pixel bytes, skips row pad and tracks row and column
// ----------------------------------------------------------------------------
module bpsd_front #(
    parameter int MAX_WIDTH  = bpsd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bpsd_pkg::DEF_MAX_HEIGHT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bpsd_pkg::t_cfg                     i_cfg,
    input  logic                               i_accept,
    input  logic                               i_action,
    input  logic [7:0]                         i_data_byte,
    input  logic [bpsd_pkg::PAL_AW-1:0]        i_entry_index,
    input  logic [bpsd_pkg::COLOR_W-1:0]       i_entry_color,
    output logic                               o_cmd_push,
    output bpsd_pkg::t_cmd                     o_cmd
);
    import bpsd_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 1);

    logic [23:0]      r_gather, n_gather;
    logic [1:0]       r_pos, n_pos;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [1:0]       r_pad, n_pad;

    logic [31:0] w_raw, w_clamp, h_raw, h_clamp;
    logic        col_last, row_last;
    logic [1:0]  bpp_lo, pad_calc;
    logic [31:0] word;

    always_comb begin
        w_raw = 32'(i_cfg.width);
        h_raw = 32'(i_cfg.height);
        if (w_raw == 32'd0) begin
            w_clamp = 32'd1;
        end else if (w_raw > 32'(MAX_WIDTH)) begin
            w_clamp = 32'(MAX_WIDTH);
        end else begin
            w_clamp = w_raw;
        end
        if (h_raw == 32'd0) begin
            h_clamp = 32'd1;
        end else if (h_raw > 32'(MAX_HEIGHT)) begin
            h_clamp = 32'(MAX_HEIGHT);
        end else begin
            h_clamp = h_raw;
        end
        col_last = (32'(r_col) + 32'd1) >= w_clamp;
        row_last = (32'(r_row) + 32'd1) >= h_clamp;
        bpp_lo   = i_cfg.fmt + 2'd1;
        pad_calc = 2'd0 - (w_clamp[1:0] * bpp_lo);
        word     = {8'd0, r_gather} | ({24'd0, i_data_byte} << {i_cfg.fmt, 3'b000});
    end

    always_comb begin
        n_gather        = r_gather;
        n_pos           = r_pos;
        n_col           = r_col;
        n_row           = r_row;
        n_pad           = r_pad;
        o_cmd_push      = 1'b0;
        o_cmd.kind      = i_action;
        o_cmd.fmt       = i_cfg.fmt;
        o_cmd.row_end   = 1'b0;
        o_cmd.image_end = 1'b0;
        o_cmd.data      = (i_action == ACT_PALETTE) ? {i_entry_index, i_entry_color} : word;
        if (i_accept) begin
            if (i_action == ACT_PALETTE) begin
                o_cmd_push = 1'b1;
            end else if (r_pad != 2'd0) begin
                n_pad = r_pad - 2'd1;
            end else if (r_pos < i_cfg.fmt) begin
                n_gather = r_gather | 24'({16'd0, i_data_byte} << {r_pos, 3'b000});
                n_pos    = r_pos + 2'd1;
            end else begin
                o_cmd_push = 1'b1;
                n_gather   = '0;
                n_pos      = '0;
                if (col_last) begin
                    o_cmd.row_end = 1'b1;
                    n_col         = '0;
                    n_pad         = pad_calc;
                    if (row_last) begin
                        o_cmd.image_end = 1'b1;
                        n_row           = '0;
                    end else begin
                        n_row = r_row + ROW_W'(1);
                    end
                end else begin
                    n_col = r_col + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gather <= '0;
            r_pos    <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_pad    <= '0;
        end else begin
            r_gather <= n_gather;
            r_pos    <= n_pos;
            r_col    <= n_col;
            r_row    <= n_row;
            r_pad    <= n_pad;
        end
    end

endmodule

// ===== sv/bpsd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap decoder back end
// palette writes and lookups, channel masking and colour assembly
// ----------------------------------------------------------------------------
module bpsd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bpsd_pkg::t_cfg              i_cfg,
    input  logic                        i_cmd_empty,
    input  bpsd_pkg::t_cmd              i_cmd,
    input  logic [bpsd_pkg::QCNT_W-1:0] i_out_count,
    output logic                        o_cmd_pop,
    output logic                        o_pix_push,
    output bpsd_pkg::t_pix              o_pix
);
    import bpsd_pkg::*;

    logic                    r_a_valid;
    logic [1:0]              r_a_fmt;
    logic [31:0]             r_a_word;
    logic                    r_a_row_end;
    logic                    r_a_image_end;
    logic [MASK_W-1:0]       r_mask_r, r_mask_g, r_mask_b;
    logic [MASK_W-1:0]       n_mask_r, n_mask_g, n_mask_b;
    logic [4:0]              r_sh_r, r_sh_g, r_sh_b;
    logic [COLOR_W-1:0]      pal_rdata;
    logic                    pal_we, pal_re;
    logic [31:0]             word_m;

    assign o_cmd_pop = !i_cmd_empty &&
        ((QCNT_W + 1)'(i_out_count) + (QCNT_W + 1)'(r_a_valid) < (QCNT_W + 1)'(QUEUE_DEPTH));
    assign pal_we = o_cmd_pop && (i_cmd.kind == ACT_PALETTE);
    assign pal_re = o_cmd_pop && (i_cmd.kind == ACT_PIXEL);

    bpsd_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (i_cmd.data[31:24]),
        .i_wdata (i_cmd.data[23:0]),
        .i_re    (pal_re),
        .i_raddr (i_cmd.data[7:0]),
        .o_rdata (pal_rdata)
    );

    // effective channel masks, defaults when all three are clear
    always_comb begin
        n_mask_r = i_cfg.red_mask;
        n_mask_g = i_cfg.green_mask;
        n_mask_b = i_cfg.blue_mask;
        if (i_cfg.red_mask == '0 && i_cfg.green_mask == '0 && i_cfg.blue_mask == '0) begin
            if (i_cfg.fmt == FMT_MASK16) begin
                n_mask_r = DEF16_R;
                n_mask_g = DEF16_G;
                n_mask_b = DEF16_B;
            end else begin
                n_mask_r = DEF32_R;
                n_mask_g = DEF32_G;
                n_mask_b = DEF32_B;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mask_r <= n_mask_r;
        r_mask_g <= n_mask_g;
        r_mask_b <= n_mask_b;
        r_sh_r   <= trailing_zeros(n_mask_r);
        r_sh_g   <= trailing_zeros(n_mask_g);
        r_sh_b   <= trailing_zeros(n_mask_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= pal_re;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pal_re) begin
            r_a_fmt       <= i_cmd.fmt;
            r_a_word      <= i_cmd.data;
            r_a_row_end   <= i_cmd.row_end;
            r_a_image_end <= i_cmd.image_end;
        end
    end

    always_comb begin
        word_m          = (r_a_fmt == FMT_MASK16) ? {16'd0, r_a_word[15:0]} : r_a_word;
        o_pix.row_end   = r_a_row_end;
        o_pix.image_end = r_a_image_end;
        unique case (r_a_fmt)
            FMT_PAL8: begin
                o_pix.red   = pal_rdata[23:16];
                o_pix.green = pal_rdata[15:8];
                o_pix.blue  = pal_rdata[7:0];
            end
            FMT_RGB24: begin
                o_pix.red   = r_a_word[23:16];
                o_pix.green = r_a_word[15:8];
                o_pix.blue  = r_a_word[7:0];
            end
            default: begin
                o_pix.red   = mask_channel(word_m, r_mask_r, r_sh_r);
                o_pix.green = mask_channel(word_m, r_mask_g, r_sh_g);
                o_pix.blue  = mask_channel(word_m, r_mask_b, r_sh_b);
            end
        endcase
    end

    assign o_pix_push = r_a_valid;

endmodule

// ===== sv/bmp_pixel_stream_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap pixel stream decoder
// decodes bottom-up bitmap pixel bytes and palette loads into rgb pixels
// ----------------------------------------------------------------------------
// channel   handshake          payload
// input     push / full        i_action, i_data_byte, i_entry_index, i_entry_color
// result    empty / pop        o_red, o_green, o_blue, o_row_end, o_image_end
// config    i_cfg_we           i_cfg_index, i_cfg_data
//
// one item per cycle while full is low; a pixel reaches the result side from the
// item that completes it, through a four-entry command queue and a palette
// ram with registered read feeding a four-entry result queue
// full rises only once both queues have filled while pop stays low
// synchronous reset, no clearing pass; palette entries hold nothing until written
// ----------------------------------------------------------------------------
module bmp_pixel_stream_decoder_top #(
    parameter int MAX_WIDTH  = bpsd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bpsd_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              i_action,
    input  logic [7:0]                        i_data_byte,
    input  logic [bpsd_pkg::PAL_AW-1:0]       i_entry_index,
    input  logic [bpsd_pkg::COLOR_W-1:0]      i_entry_color,
    output logic                              empty,
    input  logic                              pop,
    output logic [7:0]                        o_red,
    output logic [7:0]                        o_green,
    output logic [7:0]                        o_blue,
    output logic                              o_row_end,
    output logic                              o_image_end,
    input  logic                              i_cfg_we,
    input  logic [bpsd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bpsd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bpsd_pkg::*;

    t_cfg              r_cfg;
    t_cmd              front_cmd, queue_cmd;
    t_pix              back_pix, out_pix;
    logic              accept;
    logic              cmd_push, cmd_pop, cmd_empty;
    logic              pix_push;
    logic [QCNT_W-1:0] out_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fmt        <= FMT_RGB24;
            r_cfg.width      <= DIM_W'(1);
            r_cfg.height     <= DIM_W'(1);
            r_cfg.red_mask   <= '0;
            r_cfg.green_mask <= '0;
            r_cfg.blue_mask  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FORMAT:     r_cfg.fmt        <= i_cfg_data[1:0];
                CFG_WIDTH:      r_cfg.width      <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT:     r_cfg.height     <= i_cfg_data[DIM_W-1:0];
                CFG_RED_MASK:   r_cfg.red_mask   <= i_cfg_data[MASK_W-1:0];
                CFG_GREEN_MASK: r_cfg.green_mask <= i_cfg_data[MASK_W-1:0];
                CFG_BLUE_MASK:  r_cfg.blue_mask  <= i_cfg_data[MASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign accept = push && !full;

    bpsd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_accept      (accept),
        .i_action      (i_action),
        .i_data_byte   (i_data_byte),
        .i_entry_index (i_entry_index),
        .i_entry_color (i_entry_color),
        .o_cmd_push    (cmd_push),
        .o_cmd         (front_cmd)
    );

    bpsd_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (front_cmd),
        .i_pop   (cmd_pop),
        .o_data  (queue_cmd),
        .o_count (),
        .o_full  (full),
        .o_empty (cmd_empty)
    );

    bpsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (queue_cmd),
        .i_out_count (out_count),
        .o_cmd_pop   (cmd_pop),
        .o_pix_push  (pix_push),
        .o_pix       (back_pix)
    );

    bpsd_fifo #(
        .WIDTH ($bits(t_pix)),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (pix_push),
        .i_data  (back_pix),
        .i_pop   (pop),
        .o_data  (out_pix),
        .o_count (out_count),
        .o_full  (),
        .o_empty (empty)
    );

    assign o_red       = out_pix.red;
    assign o_green     = out_pix.green;
    assign o_blue      = out_pix.blue;
    assign o_row_end   = out_pix.row_end;
    assign o_image_end = out_pix.image_end;

endmodule

// ===== sv/bpsd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap decoder port checker
// checks reset behaviour, result flags and stalled results on the ports
// ----------------------------------------------------------------------------
module bpsd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_red,
    input logic [7:0] o_green,
    input logic [7:0] o_blue,
    input logic       o_row_end,
    input logic       o_image_end
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result side not empty after reset");

    a_reset_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input side full after reset");

    a_image_end_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_image_end |-> o_row_end)
        else $error("image end without row end");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_red) && $stable(o_green) &&
                           $stable(o_blue) && $stable(o_row_end) && $stable(o_image_end))
        else $error("waiting result changed");

endmodule

bind bmp_pixel_stream_decoder_top bpsd_checker u_checker (.*);
